// File: design/rds_pkg.sv
// ----------------------------------------------------------------------------
// rds_pkg
// Shared constants, types and helpers of the radix digit string block.
// ----------------------------------------------------------------------------
package rds_pkg;

  // default sizes
  localparam int DEF_VALUE_WIDTH = 31;
  localparam int DEF_MAX_DIGITS  = 32;

  // dividend bits consumed by the divider in one cycle
  localparam int STEP_BITS = 8;

  localparam int RADIX_W = 5;
  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] BASE_MIN    = 5'd2;
  localparam logic [RADIX_W-1:0] BASE_MAX    = 5'd16;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_A    = 7'h61;
  localparam logic [CHAR_W-1:0] ASCII_F    = 7'h66;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_EMIT
  } back_state_t;

  // divider control and status
  typedef struct packed {
    logic               start;
    logic [RADIX_W-1:0] base;
  } div_ctl_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIGIT_W-1:0] rem;
  } div_sts_t;

  // bases outside 2..16 are pulled to the nearest end
  function automatic logic [RADIX_W-1:0] clamp_base(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] b;
    b = r;
    if (r < BASE_MIN) begin
      b = BASE_MIN;
    end else if (r > BASE_MAX) begin
      b = BASE_MAX;
    end
    return b;
  endfunction

  // lower-case ASCII of one digit
  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = ASCII_ZERO + {3'b000, d};
    end else begin
      c = ASCII_A + {3'b000, d} - 7'd10;
    end
    if (c > ASCII_F) begin
      c = ASCII_F;
    end
    return c;
  endfunction

endpackage

// File: design/rds_front.sv
// ----------------------------------------------------------------------------
// rds_front
// Holds the radix register, takes items, pairs each with its clamped base
// and queues them in a two-entry FIFO for the conversion side.
// ----------------------------------------------------------------------------
module rds_front import rds_pkg::*; #(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [RADIX_W-1:0]     cfg_data,
  input  logic                   push,
  output logic                   full,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   q_valid,
  output logic [VALUE_WIDTH-1:0] q_value,
  output logic [RADIX_W-1:0]     q_base,
  input  logic                   q_take
);

  logic [RADIX_W-1:0]     radix;
  logic [VALUE_WIDTH-1:0] fifo_value [2];
  logic [RADIX_W-1:0]     fifo_base  [2];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [1:0]             fill;
  logic                   do_push;
  logic                   do_pop;

  assign full    = (fill == 2'd2);
  assign q_valid = (fill != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;
  assign q_value = fifo_value[rd_ptr];
  assign q_base  = fifo_base[rd_ptr];

  // radix register
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_write) begin
      radix <= cfg_data;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      fifo_value[wr_ptr] <= value;
      fifo_base[wr_ptr]  <= clamp_base(radix);
    end
  end

endmodule

// File: design/rds_div.sv
// ----------------------------------------------------------------------------
// rds_div
// Iterative divider by a small base: restoring division over STEP_BITS
// dividend bits per cycle, giving quotient and remainder after the last chunk.
// ----------------------------------------------------------------------------
module rds_div import rds_pkg::*; #(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  div_ctl_t               ctl,
  input  logic [VALUE_WIDTH-1:0] dividend,
  output div_sts_t               sts,
  output logic [VALUE_WIDTH-1:0] quotient
);

  localparam int CHUNKS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_W  = CHUNKS * STEP_BITS;
  localparam int CNT_W  = $clog2(CHUNKS + 1);

  logic [PAD_W-1:0]     work;
  logic [PAD_W-1:0]     work_next;
  logic [DIGIT_W-1:0]   rem;
  logic [DIGIT_W-1:0]   rem_next;
  logic [RADIX_W-1:0]   base;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic                 done;

  assign sts.busy = busy;
  assign sts.done = done;
  assign sts.rem  = rem;
  assign quotient = work[VALUE_WIDTH-1:0];

  // one chunk of restoring division: top bits in, quotient bits in at the bottom
  always_comb begin
    logic [STEP_BITS-1:0] chunk;
    logic [DIGIT_W-1:0]   r;
    logic [RADIX_W-1:0]   t;
    chunk = work[PAD_W-1 -: STEP_BITS];
    r     = rem;
    work_next = work << STEP_BITS;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      t = {r, chunk[i]};
      if (t >= base) begin
        t = t - base;
        work_next[i] = 1'b1;
      end else begin
        work_next[i] = 1'b0;
      end
      r = t[DIGIT_W-1:0];
    end
    rem_next = r;
  end

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(CHUNKS);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end else if (ctl.start) begin
      work <= PAD_W'(dividend);
      rem  <= '0;
      base <= ctl.base;
    end
  end

endmodule

// File: design/rds_back.sv
// ----------------------------------------------------------------------------
// rds_back
// Conversion side: drives the divider once per digit, keeps the remainders
// in the digit store, then reads them back most significant first into the
// result register.
// ----------------------------------------------------------------------------
module rds_back import rds_pkg::*; #(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int MAX_DIGITS  = DEF_MAX_DIGITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  logic [VALUE_WIDTH-1:0] q_value,
  input  logic [RADIX_W-1:0]     q_base,
  output logic                   q_take,
  output logic                   empty,
  input  logic                   pop,
  output logic [CHAR_W-1:0]      digit_char,
  output logic                   last_digit
);

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  back_state_t            state;
  back_state_t            state_next;
  div_ctl_t               div_ctl;
  div_sts_t               div_sts;
  logic [VALUE_WIDTH-1:0] dividend;
  logic [VALUE_WIDTH-1:0] quotient;
  logic [RADIX_W-1:0]     cur_base;
  logic [CNT_W-1:0]       count;
  logic [IDX_W-1:0]       rd_idx;
  logic                   rd_issue;
  logic                   rd_valid;
  logic [DIGIT_W-1:0]     rd_data;
  logic                   rd_last;
  logic                   out_valid;
  logic [CHAR_W-1:0]      out_char;
  logic                   out_last;
  logic                   div_final;
  logic [DIGIT_W-1:0]     store [MAX_DIGITS];

  rds_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (dividend),
    .sts      (div_sts),
    .quotient (quotient)
  );

  assign empty      = !out_valid;
  assign digit_char = out_char;
  assign last_digit = out_last;

  // last digit of this value: quotient exhausted or store full
  assign div_final = (quotient == '0) || (count == CNT_W'(MAX_DIGITS - 1));

  // a read may start when the result register is free by the next edge
  assign rd_issue = (state == BK_EMIT) && !rd_valid && (!out_valid || pop);

  // next state and divider control
  always_comb begin
    state_next   = state;
    q_take       = 1'b0;
    div_ctl.start = 1'b0;
    div_ctl.base  = cur_base;
    dividend     = quotient;
    case (state)
      BK_IDLE: begin
        div_ctl.base = q_base;
        dividend     = q_value;
        if (q_valid) begin
          q_take        = 1'b1;
          div_ctl.start = 1'b1;
          state_next    = BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_sts.done) begin
          if (div_final) begin
            state_next = BK_EMIT;
          end else begin
            div_ctl.start = 1'b1;
          end
        end
      end
      BK_EMIT: begin
        if (rd_issue && (rd_idx == '0)) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // digit count, read index and current base
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      rd_idx   <= '0;
      cur_base <= BASE_MIN;
    end else begin
      if (state == BK_IDLE && q_valid) begin
        count    <= '0;
        cur_base <= q_base;
      end else if (state == BK_DIV && div_sts.done) begin
        count <= count + CNT_W'(1);
        if (div_final) begin
          rd_idx <= count[IDX_W-1:0];
        end
      end else if (rd_issue) begin
        rd_idx <= rd_idx - IDX_W'(1);
      end
    end
  end

  // digit store: one write, one registered read
  always_ff @(posedge clk) begin
    if (state == BK_DIV && div_sts.done) begin
      store[count[IDX_W-1:0]] <= div_sts.rem;
    end
    if (rd_issue) begin
      rd_data <= store[rd_idx];
      rd_last <= (rd_idx == '0);
    end
  end

  // read pending and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid <= rd_issue;
      if (rd_valid) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      out_char <= digit_ascii(rd_data);
      out_last <= rd_last;
    end
  end

endmodule

// File: design/radix_digit_string.sv
// ----------------------------------------------------------------------------
// radix_digit_string
// Converts a non-negative integer to its lower-case ASCII digits in a base
// from 2 to 16, most significant digit first, last digit marked.
// ----------------------------------------------------------------------------
// Each digit costs one pass of the divider, which takes eight dividend bits
// per cycle; an item is converted in full before its digits leave, paced by
// the registered digit-store read, which waits for each read to land before
// the next. One item converts at a time; two more may wait in the input
// queue. Reset sets radix to 10 and empties the queues; the digit store is
// not cleared.
// ----------------------------------------------------------------------------
module radix_digit_string import rds_pkg::*; #(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int MAX_DIGITS  = DEF_MAX_DIGITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [RADIX_W-1:0]     cfg_data,
  input  logic                   push,
  output logic                   full,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   empty,
  input  logic                   pop,
  output logic [CHAR_W-1:0]      digit_char,
  output logic                   last_digit
);

  logic                   q_valid;
  logic [VALUE_WIDTH-1:0] q_value;
  logic [RADIX_W-1:0]     q_base;
  logic                   q_take;

  rds_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .value     (value),
    .q_valid   (q_valid),
    .q_value   (q_value),
    .q_base    (q_base),
    .q_take    (q_take)
  );

  rds_back #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_value    (q_value),
    .q_base     (q_base),
    .q_take     (q_take),
    .empty      (empty),
    .pop        (pop),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

endmodule

// File: test/tb_radix_digit_string.sv
// ----------------------------------------------------------------------------
// tb_radix_digit_string
// Self-checking bench for the radix digit string converter. Values go in
// through the push/full queue and the ASCII digits are drained through
// empty/pop. Each accepted value is converted here by a local predictor at
// the radix in force, and every digit that leaves the block is compared,
// character and last flag, with the oldest predicted digit. Directed values
// cover the field extremes, the default radix and out-of-range radix codes;
// random values then run under three idling patterns and several radices.
// ----------------------------------------------------------------------------
module tb_radix_digit_string;
  timeunit 1ns;
  timeprecision 1ps;

  import rds_pkg::*;

  localparam int VW   = DEF_VALUE_WIDTH;
  localparam int MAXD = DEF_MAX_DIGITS;
  localparam longint unsigned VALUE_MAX = (64'd1 << VW) - 64'd1;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_CFG   = 16;
  localparam int SETTLE_END   = 200;

  // one predicted output digit
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [RADIX_W-1:0]     cfg_data;
  logic                   push;
  logic                   full;
  logic [VW-1:0]          value;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [CHAR_W-1:0]      digit_char;
  logic                   last_digit;

  digit_t             expected_digits[$];
  logic [RADIX_W-1:0] radix_reg = RADIX_RESET;
  int                 send_idle_pct = 37;
  int                 recv_idle_pct = 73;
  int                 mismatch_count = 0;
  int                 items_sent = 0;
  int                 digits_checked = 0;
  int                 radix_writes = 0;
  int                 cycle_count = 0;

  radix_digit_string i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .value      (value),
    .empty      (empty),
    .pop        (pop),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d digits outstanding", cycle_count,
             expected_digits.size());
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch @%0t: %s", $time, msg);
  endtask

  // radix codes outside 2..16 fall back to the nearest end
  function automatic int effective_base();
    int b;
    b = int'(radix_reg);
    if (b < 2) begin
      b = 2;
    end else if (b > 16) begin
      b = 16;
    end
    return b;
  endfunction

  // queue the digits of one value, most significant first
  task automatic predict_digit_string(input logic [VW-1:0] v);
    logic [3:0]      digits[MAXD];
    longint unsigned q;
    longint unsigned b;
    int              n;
    digit_t          d;
    b = longint'(effective_base());
    q = longint'(v);
    n = 0;
    do begin
      digits[n] = 4'(q % b);
      q = q / b;
      n++;
    end while (q != 0 && n < MAXD);
    for (int k = n - 1; k >= 0; k--) begin
      if (digits[k] < 4'd10) begin
        d.ch = ASCII_ZERO + {3'b000, digits[k]};
      end else begin
        d.ch = ASCII_A + {3'b000, digits[k]} - 7'd10;
      end
      d.last = (k == 0);
      expected_digits.push_back(d);
    end
  endtask

  // offer one value, idling at random first, and predict on acceptance
  task automatic send_value(input logic [VW-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push  <= 1'b1;
    value <= v;
    do @(posedge clk); while (full);
    predict_digit_string(v);
    items_sent++;
  endtask

  // hold the input back until every digit has left, then settle
  task automatic wait_all_done(input int settle);
    push <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // radix writes only happen with the block idle
  task automatic set_radix(input logic [RADIX_W-1:0] r);
    wait_all_done(SETTLE_CFG);
    cfg_write <= 1'b1;
    cfg_data  <= r;
    @(posedge clk);
    cfg_write <= 1'b0;
    radix_reg = r;
    radix_writes++;
  endtask

  // random value: full width, small, near a power of the base, extreme, or shifted down
  function automatic logic [VW-1:0] random_value();
    longint unsigned p;
    longint unsigned b;
    logic [31:0]     r;
    b = longint'(effective_base());
    r = $urandom();
    case ($urandom_range(0, 9))
      0, 1, 2: return r[VW-1:0];
      3, 4:    return VW'($urandom_range(0, 2 * int'(b)));
      5, 6: begin
        p = 1;
        repeat ($urandom_range(1, VW)) begin
          if (p * b <= VALUE_MAX) p = p * b;
        end
        return $urandom_range(0, 1) ? VW'(p) : VW'(p - 1);
      end
      7:       return $urandom_range(0, 1) ? VW'(VALUE_MAX) : '0;
      default: return VW'(r >> $urandom_range(1, 31));
    endcase
  endfunction

  // receiver: random pop, compare each accepted digit
  always @(posedge clk) begin
    digit_t e;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_digits.size() == 0) begin
          report_mismatch($sformatf("digit 0x%02h with nothing expected", digit_char));
        end else begin
          e = expected_digits.pop_front();
          digits_checked++;
          if (digit_char !== e.ch) begin
            report_mismatch($sformatf("digit_char 0x%02h, expected 0x%02h",
                                      digit_char, e.ch));
          end
          if (last_digit !== e.last) begin
            report_mismatch($sformatf("last_digit %b, expected %b", last_digit, e.last));
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // radix left at its reset value
  task automatic test_default_radix();
    send_value('0);
    send_value(VW'(1));
    send_value(VW'(9));
    send_value(VW'(10));
    send_value(VW'(VALUE_MAX));
  endtask

  // longest digit strings
  task automatic test_base_two();
    set_radix(5'd2);
    send_value('0);
    send_value(VW'(1));
    send_value(VW'(VALUE_MAX));
    send_value(VW'(32'h2aaa_aaaa));
  endtask

  // every letter digit
  task automatic test_base_sixteen();
    set_radix(5'd16);
    send_value('0);
    send_value(VW'(15));
    send_value(VW'(16));
    send_value(VW'(VALUE_MAX));
    send_value(VW'(32'h0abc_def0));
  endtask

  // radix below two and above sixteen
  task automatic test_clamped_radix();
    set_radix(5'd0);
    send_value(VW'(5));
    set_radix(5'd1);
    send_value(VW'(6));
    set_radix(5'd17);
    send_value(VW'(255));
    set_radix(5'd31);
    send_value(VW'(VALUE_MAX - 1));
  endtask

  task automatic test_odd_bases();
    set_radix(5'd3);
    send_value(VW'(VALUE_MAX));
    set_radix(5'd15);
    send_value(VW'(14));
    set_radix(5'd7);
    send_value(VW'(48));
  endtask

  // random values under one idling pattern, one block per radix,
  // with one full drain halfway through the first block
  task automatic test_random_phase(input int s_pct, input int r_pct,
                                   input logic [RADIX_W-1:0] plan[4],
                                   input int per_radix);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int s = 0; s < 4; s++) begin
      set_radix(plan[s]);
      for (int i = 0; i < per_radix; i++) begin
        if (s == 0 && i == per_radix / 2) begin
          wait_all_done(0);
        end
        send_value(random_value());
      end
    end
  endtask

  // main sequence
  initial begin
    logic [RADIX_W-1:0] plan[4];
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data  <= '0;
    push      <= 1'b0;
    value     <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_default_radix();
    test_base_two();
    test_base_sixteen();
    test_clamped_radix();
    test_odd_bases();

    plan = '{5'd2, 5'd16, RADIX_W'($urandom_range(2, 16)), RADIX_W'($urandom_range(0, 31))};
    test_random_phase(37, 73, plan, 24);
    plan = '{5'd16, 5'd2, 5'd31, RADIX_W'($urandom_range(0, 31))};
    test_random_phase(73, 37, plan, 24);
    plan = '{5'd0, 5'd10, RADIX_W'($urandom_range(2, 16)), RADIX_W'($urandom_range(0, 31))};
    test_random_phase(0, 0, plan, 24);

    wait_all_done(SETTLE_END);
    if (expected_digits.size() != 0) begin
      report_mismatch($sformatf("%0d digits never arrived", expected_digits.size()));
    end

    $display("Converted %0d values into %0d checked digits over %0d radix writes,",
             items_sent, digits_checked, radix_writes);
    $display("including clamped radix codes and three idling patterns; %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
design/rds_pkg.sv
design/rds_front.sv
design/rds_div.sv
design/rds_back.sv
design/radix_digit_string.sv
test/tb_radix_digit_string.sv
